/* rtl/assert_macros.svh */
// Assertion macros for the RTL files; the top level includes them.
// Depends on nothing; SYNTH selects empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("label");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("label");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

/* rtl/casl_pkg.sv */
// Package for the curvature/approach speed limiter: widths, register
// indexes and the pipeline payload types. No dependencies.
package casl_pkg;
  localparam int SPEED_W = 15;
  localparam int REQ_W   = 16;
  localparam int DIST_W  = 24;
  localparam int CURV_W  = 24;
  localparam int PROD_W  = 48;
  localparam int NUM_W   = SPEED_W + 24;   // v << 24
  localparam int SD_W    = SPEED_W + DIST_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE = 2'd0, REG_RADIUS_LIM = 2'd1,
    REG_SLOW_ZONE = 2'd2, REG_MIN_APPROACH = 2'd3
  } cfg_reg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [SPEED_W-1:0] v;
    logic               cdiv;   // curvature division needed
    logic [PROD_W-1:0]  prod;
    logic               adiv;   // approach stage active
    logic [DIST_W-1:0]  goal_d;
  } front_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] speed_out;
    logic [SPEED_W-1:0] curvature_cap;
    logic [SPEED_W-1:0] approach_cap;
    logic               curvature_limited;
    logic               approach_limited;
  } result_t;
endpackage

/* rtl/casl_if.sv */
// Valid/ready channel interfaces for the speed limiter.
// Depends on casl_pkg.
interface casl_in_if import casl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic signed [REQ_W-1:0]  speed_request;
  logic signed [CURV_W-1:0] curvature;
  logic [DIST_W-1:0]  goal_distance;
  logic               distance_known;
  modport source (output valid, speed_request, curvature, goal_distance, distance_known,
                  input ready);
  modport sink (input valid, speed_request, curvature, goal_distance, distance_known,
                output ready);
endinterface

interface casl_out_if import casl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] speed_out;
  logic [SPEED_W-1:0] curvature_cap;
  logic [SPEED_W-1:0] approach_cap;
  logic               curvature_limited;
  logic               approach_limited;
  modport source (output valid, speed_out, curvature_cap, approach_cap, curvature_limited,
                  approach_limited, input ready);
  modport sink (input valid, speed_out, curvature_cap, approach_cap, curvature_limited,
                approach_limited, output ready);
endinterface

interface casl_cfg_if import casl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/casl_front.sv */
// Front end: clamps the speed, forms |kappa| times the radius limit and
// classifies the item. Two registered stages. Depends on casl_pkg.
module casl_front import casl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [REQ_W-1:0]  speed_request,
  input  logic signed [CURV_W-1:0] curvature,
  input  logic [DIST_W-1:0]        goal_distance,
  input  logic                     distance_known,
  input  logic                     enable,
  input  logic [DIST_W-1:0]        radius_lim,
  input  logic [DIST_W-1:0]        slow_zone,
  output logic                     fv_valid,
  input  logic                     fv_ready,
  output front_item_t              fv_item
);
  logic               s1_valid_r;
  logic [SPEED_W-1:0] s1_v_r;
  logic [CURV_W-1:0]  s1_k_r;
  logic               s1_kz_r, s1_adiv_r;
  logic [DIST_W-1:0]  s1_dist_r;
  logic               s2_valid_r;
  front_item_t        s2_item_r;
  logic [PROD_W-1:0]  prod;
  logic               s1_adv, s2_adv;

  assign s2_adv   = !s2_valid_r || fv_ready;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_ready = s1_adv;
  assign prod     = PROD_W'(s1_k_r) * PROD_W'(radius_lim);

  // stage 1: clamp, magnitude, approach check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
    if (s1_adv && in_valid) begin
      s1_v_r    <= speed_request[REQ_W-1] ? '0 : speed_request[SPEED_W-1:0];
      s1_k_r    <= curvature[CURV_W-1] ? CURV_W'(-curvature) : curvature;
      s1_kz_r   <= (curvature == '0) || !enable || (radius_lim == '0);
      s1_adiv_r <= enable && (slow_zone != '0) && distance_known &&
                   (goal_distance < slow_zone);
      s1_dist_r <= goal_distance;
    end
  end

  // stage 2: product and curvature classification
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_r <= s1_valid_r;
    end
    if (s2_adv && s1_valid_r) begin
      s2_item_r.v      <= s1_v_r;
      s2_item_r.prod   <= prod;
      s2_item_r.cdiv   <= !s1_kz_r && (prod > (PROD_W'(1) << 24));
      s2_item_r.adiv   <= s1_adiv_r;
      s2_item_r.goal_d <= s1_dist_r;
    end
  end

  assign fv_valid = s2_valid_r;
  assign fv_item  = s2_item_r;
endmodule

/* rtl/casl_queue.sv */
// Short FIFO between front and back ends.
// Depends on casl_pkg.
module casl_queue import casl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_valid,
  output logic        wr_ready,
  input  front_item_t wr_item,
  output logic        rd_valid,
  input  logic        rd_ready,
  output front_item_t rd_item
);
  front_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QPTR_W:0]     cnt_r;
  logic                wr, rd;

  assign wr_ready = cnt_r != (QPTR_W+1)'(QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_item;
  end
endmodule

/* rtl/casl_back.sv */
// Back end: pipelined restoring dividers for both caps, one quotient bit
// per stage, then the floor/min logic and an output register.
// Depends on casl_pkg.
module casl_back import casl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               bk_valid,
  output logic               bk_ready,
  input  front_item_t        bk_item,
  input  logic [DIST_W-1:0]  slow_zone,
  input  logic [SPEED_W-1:0] min_approach_speed,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res
);
  // curvature divider: (v<<24)/prod; quotient fits SPEED_W bits since prod>2^24
  localparam int CST = SPEED_W;
  // approach divider: (ccap*goal_d)/slow_zone; quotient < ccap, SPEED_W bits
  localparam int AST = SPEED_W;

  typedef struct packed {
    logic [SPEED_W-1:0] v;
    logic               cdiv;
    logic               adiv;
    logic [DIST_W-1:0]  goal_d;
  } ctl_t;

  logic adv;
  logic out_valid_r;
  result_t out_r;
  assign adv = !out_valid_r || res_ready;
  assign bk_ready = adv;

  // curvature divider pipeline
  logic               cv_r  [CST+1];
  ctl_t               cc_r  [CST+1];
  logic [PROD_W-1:0]  cd_r  [CST+1];
  logic [NUM_W-1:0]   cn_r  [CST+1];  // numerator, carried along unchanged
  logic [PROD_W:0]    crm_r [CST+1];
  logic [SPEED_W-1:0] cq_r  [CST+1];

  always_comb begin
    cv_r[0]  = bk_valid;
    cc_r[0]  = '{v: bk_item.v, cdiv: bk_item.cdiv, adiv: bk_item.adiv,
                 goal_d: bk_item.goal_d};
    cd_r[0]  = bk_item.prod;
    cn_r[0]  = {bk_item.v, 24'd0};
    // bits above position SPEED_W-1 of quotient are zero: preload remainder
    crm_r[0] = (PROD_W+1)'(bk_item.v) << 24 >> SPEED_W;
    cq_r[0]  = '0;
  end

  for (genvar i = 0; i < CST; i++) begin : g_cdiv
    logic [PROD_W:0] t;
    logic [PROD_W:0] sub;
    // next numerator bit, MSB first below the preloaded part
    assign t   = {crm_r[i][PROD_W-1:0], cn_r[i][SPEED_W-1-i]};
    assign sub = t - {1'b0, cd_r[i]};
    always_ff @(posedge clk) begin
      if (!rst_n) cv_r[i+1] <= 1'b0;
      else if (adv) cv_r[i+1] <= cv_r[i];
      if (adv) begin
        cc_r[i+1]  <= cc_r[i];
        cd_r[i+1]  <= cd_r[i];
        cn_r[i+1]  <= cn_r[i];
        crm_r[i+1] <= sub[PROD_W] ? t : sub;
        cq_r[i+1]  <= {cq_r[i][SPEED_W-2:0], !sub[PROD_W]};
      end
    end
  end

  // approach divider pipeline
  logic               av_r  [AST+2];
  ctl_t               ac_r  [AST+2];
  logic [SPEED_W-1:0] acap_r[AST+2];
  logic [SD_W-1:0]    an_r  [AST+2];
  logic [DIST_W:0]    arm_r [AST+2];
  logic [SPEED_W-1:0] aq_r  [AST+2];
  logic               cl_r  [AST+2];
  logic [SPEED_W-1:0] ccap0;

  assign ccap0 = cc_r[CST].cdiv ? cq_r[CST] : cc_r[CST].v;

  // multiply stage
  always_ff @(posedge clk) begin
    if (!rst_n) av_r[0] <= 1'b0;
    else if (adv) av_r[0] <= cv_r[CST];
    if (adv) begin
      ac_r[0]   <= cc_r[CST];
      acap_r[0] <= ccap0;
      cl_r[0]   <= cc_r[CST].cdiv && (ccap0 < cc_r[CST].v);
      an_r[0]   <= SD_W'(ccap0) * SD_W'(cc_r[CST].goal_d);
    end
  end

  always_comb begin
    av_r[1] = av_r[0]; ac_r[1] = ac_r[0]; acap_r[1] = acap_r[0]; cl_r[1] = cl_r[0];
    an_r[1] = an_r[0];
    // quotient < 2^SPEED_W, so top DIST_W bits of numerator preload remainder
    arm_r[1] = {1'b0, an_r[0][SD_W-1 -: DIST_W]};
    aq_r[1]  = '0;
  end

  for (genvar j = 0; j < AST; j++) begin : g_adiv
    logic [DIST_W:0] t;
    logic [DIST_W:0] sub;
    assign t   = {arm_r[j+1][DIST_W-1:0], an_r[j+1][SPEED_W-1-j]};
    assign sub = t - {1'b0, slow_zone};
    always_ff @(posedge clk) begin
      if (!rst_n) av_r[j+2] <= 1'b0;
      else if (adv) av_r[j+2] <= av_r[j+1];
      if (adv) begin
        ac_r[j+2]   <= ac_r[j+1];
        acap_r[j+2] <= acap_r[j+1];
        cl_r[j+2]   <= cl_r[j+1];
        an_r[j+2]   <= an_r[j+1];
        arm_r[j+2]  <= sub[DIST_W] ? t : sub;
        aq_r[j+2]   <= {aq_r[j+1][SPEED_W-2:0], !sub[DIST_W]};
      end
    end
  end

  // floor, cap and output register
  logic [SPEED_W-1:0] ccap, scaled, a, acap;
  always_comb begin
    ccap   = acap_r[AST+1];
    scaled = aq_r[AST+1];
    a      = (scaled > min_approach_speed) ? scaled : min_approach_speed;
    if (a > ccap) a = ccap;
    acap   = ac_r[AST+1].adiv ? a : ccap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (adv) out_valid_r <= av_r[AST+1];
    if (adv) begin
      out_r.speed_out         <= acap;
      out_r.curvature_cap     <= ccap;
      out_r.approach_cap      <= acap;
      out_r.curvature_limited <= cl_r[AST+1];
      out_r.approach_limited  <= acap < ccap;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;
endmodule

/* rtl/curvature_approach_speed_limiter.sv */
// Top level of the curvature/approach speed limiter.
// Depends on casl_pkg, casl_if, casl_front, casl_queue, casl_back, assert_macros.svh.

// One result per input item, one item per cycle sustained while the output is
// ready. Items pass the front stages, the queue, 15 curvature-divider stages,
// one multiply stage, 15 approach-divider stages and the output register,
// most of them in the two bit-per-stage restoring dividers. Output backpressure
// stalls the back pipeline; the four-entry queue absorbs the front's items in
// flight. Configuration writes are always taken and apply from the next cycle.
`include "assert_macros.svh"
module curvature_approach_speed_limiter import casl_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  casl_in_if.sink     in_ch,
  casl_out_if.source  out_ch,
  casl_cfg_if.sink    cfg_ch
);
  logic               enable_r;
  logic [DIST_W-1:0]  radius_lim_r, slow_zone_r;
  logic [SPEED_W-1:0] min_approach_r;

  // configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b1; radius_lim_r <= '0; slow_zone_r <= '0; min_approach_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_ENABLE:       enable_r       <= cfg_ch.data[0];
        REG_RADIUS_LIM:   radius_lim_r   <= cfg_ch.data;
        REG_SLOW_ZONE:    slow_zone_r    <= cfg_ch.data;
        REG_MIN_APPROACH: min_approach_r <= cfg_ch.data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  logic fv_valid, fv_ready, bk_valid, bk_ready;
  front_item_t fv_item, bk_item;
  result_t res;

  casl_front u_front (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .speed_request(in_ch.speed_request), .curvature(in_ch.curvature),
    .goal_distance(in_ch.goal_distance), .distance_known(in_ch.distance_known),
    .enable(enable_r), .radius_lim(radius_lim_r), .slow_zone(slow_zone_r),
    .fv_valid, .fv_ready, .fv_item
  );

  casl_queue u_queue (
    .clk, .rst_n, .wr_valid(fv_valid), .wr_ready(fv_ready), .wr_item(fv_item),
    .rd_valid(bk_valid), .rd_ready(bk_ready), .rd_item(bk_item)
  );

  casl_back u_back (
    .clk, .rst_n, .bk_valid, .bk_ready, .bk_item,
    .slow_zone(slow_zone_r), .min_approach_speed(min_approach_r),
    .res_valid(out_ch.valid), .res_ready(out_ch.ready), .res
  );

  assign out_ch.speed_out         = res.speed_out;
  assign out_ch.curvature_cap     = res.curvature_cap;
  assign out_ch.approach_cap      = res.approach_cap;
  assign out_ch.curvature_limited = res.curvature_limited;
  assign out_ch.approach_limited  = res.approach_limited;

  `ASSERT_IMPLIES(a_speed_le_ccap, clk, rst_n, out_ch.valid, out_ch.speed_out <= out_ch.curvature_cap)
  `ASSERT_IMPLIES(a_aflag, clk, rst_n, out_ch.valid, out_ch.approach_limited == (out_ch.approach_cap < out_ch.curvature_cap))
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.speed_out))
endmodule
